// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; every other file of the block refers to this package by scoped names.
package lkvc_pkg;

    localparam int unsigned KEY_W      = 16;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned CFG_W      = 5;
    localparam int unsigned DEPTH_DEF  = 16;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_out_item;

    // per-cell flags seen by the control logic
    typedef struct packed {
        logic match;       // valid and key equals the lookup key
        logic last_valid;  // least recent valid entry
        logic first_free;  // first empty cell behind the valid run
    } t_cell_status;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache: cell row, control, output register.
// Depends on lkvc_pkg and lkvc_cell.
//
// Entries sit in a row of DEPTH cells ordered by recency: cell 0 holds the most recent entry
// and the valid entries always form an unbroken run from cell 0. Every cell compares its key
// with the incoming one in parallel; a get or put then moves the touched, evicted or freed
// position to the head by shifting the cells in front of it back one place, all in the same
// cycle. One item is accepted per clock whenever the output register is empty or being
// drained, and its result beat appears on the cycle after acceptance; the path that sets the
// clock is the key compare across the row followed by the one-hot select and shift enables.
// The capacity register accepts a write on every cycle (o_cfg_ready is tied high), takes
// effect from the next item, and reads DEPTH after reset; 0 acts as 1 and values above DEPTH
// act as DEPTH. Lowering it below the current fill keeps the extra entries; each put miss
// then evicts exactly one.
module lru_key_value_cache #(
    parameter int unsigned DEPTH = lkvc_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lkvc_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lkvc_pkg::t_out_item        o_out_data
);

    localparam int unsigned DW = $clog2(DEPTH + 1);
    localparam int unsigned CW = (lkvc_pkg::CFG_W > DW) ? lkvc_pkg::CFG_W : DW;

    logic [CW-1:0]              r_cap;
    logic                       r_out_valid;
    lkvc_pkg::t_out_item        r_out_data;
    lkvc_pkg::t_out_item        n_out_data;

    logic [lkvc_pkg::KEY_W-1:0] cell_key   [DEPTH];
    logic [lkvc_pkg::VAL_W-1:0] cell_val   [DEPTH];
    logic [lkvc_pkg::KEY_W-1:0] shift_key  [DEPTH];
    logic [lkvc_pkg::VAL_W-1:0] shift_val  [DEPTH];
    lkvc_pkg::t_cell_status     cell_st    [DEPTH];
    logic [DEPTH-1:0]           valid_vec;
    logic [DEPTH-1:0]           shift_vld;
    logic [DEPTH-1:0]           prev_vld;
    logic [DEPTH-1:0]           next_vld;
    logic [DEPTH-1:0]           match_vec;
    logic [DEPTH-1:0]           last_vec;
    logic [DEPTH-1:0]           free_vec;
    logic [DEPTH-1:0]           at_cap;
    logic [DEPTH-1:0]           stop_vec;
    logic [DEPTH-1:0]           load_en;

    logic [CW-1:0]              cap_ext;
    logic [CW-1:0]              cap_eff;
    logic [CW-1:0]              cap_m1;
    logic                       accept;
    logic                       is_put;
    logic                       hit;
    logic                       full;
    logic                       evict;
    logic [lkvc_pkg::VAL_W-1:0] hit_val;
    logic [lkvc_pkg::KEY_W-1:0] ev_key;
    logic [lkvc_pkg::VAL_W-1:0] head_val;

    assign o_cfg_ready = 1'b1;

    // wide enough to hold DEPTH itself as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CW'(DEPTH);
        end else if (i_cfg_valid) begin
            r_cap <= CW'(i_cfg_data);
        end
    end

    // clamp capacity to 1..DEPTH
    always_comb begin
        cap_ext = r_cap;
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > CW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end
        cap_m1 = cap_eff - CW'(1);
    end

    assign accept = i_in_valid && o_in_ready;
    assign is_put = (i_in_data.cmd == lkvc_pkg::CMD_PUT);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign shift_key[gi] = i_in_data.lookup_key;
                assign shift_val[gi] = head_val;
                assign shift_vld[gi] = 1'b1;
                assign prev_vld[gi]  = 1'b1;
            end else begin : g_body
                assign shift_key[gi] = cell_key[gi-1];
                assign shift_val[gi] = cell_val[gi-1];
                assign shift_vld[gi] = valid_vec[gi-1];
                assign prev_vld[gi]  = valid_vec[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign next_vld[gi] = 1'b0;
            end else begin : g_mid
                assign next_vld[gi] = valid_vec[gi+1];
            end

            assign match_vec[gi] = cell_st[gi].match;
            assign last_vec[gi]  = cell_st[gi].last_valid;
            assign free_vec[gi]  = cell_st[gi].first_free;
            assign at_cap[gi]    = (cap_m1 == CW'(gi));
            // a cell moves when the stop position lies at or behind it
            assign load_en[gi]   = accept && (|stop_vec[DEPTH-1:gi]);

            lkvc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (load_en[gi]),
                .i_key        (shift_key[gi]),
                .i_value      (shift_val[gi]),
                .i_valid      (shift_vld[gi]),
                .i_lookup_key (i_in_data.lookup_key),
                .i_prev_valid (prev_vld[gi]),
                .i_next_valid (next_vld[gi]),
                .o_key        (cell_key[gi]),
                .o_value      (cell_val[gi]),
                .o_valid      (valid_vec[gi]),
                .o_status     (cell_st[gi])
            );
        end
    endgenerate

    always_comb begin
        hit_val = '0;
        ev_key  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_val = hit_val | (cell_val[i] & {lkvc_pkg::VAL_W{match_vec[i]}});
            ev_key  = ev_key | (cell_key[i] & {lkvc_pkg::KEY_W{last_vec[i]}});
        end
    end

    assign hit      = |match_vec;
    assign full     = |(valid_vec & at_cap);
    assign evict    = is_put && !hit && full;
    assign head_val = is_put ? i_in_data.write_value : hit_val;

    always_comb begin
        if (hit) begin
            stop_vec = match_vec;
        end else if (is_put) begin
            stop_vec = full ? last_vec : free_vec;
        end else begin
            stop_vec = '0;
        end
    end

    always_comb begin
        n_out_data.hit         = hit;
        n_out_data.read_value  = is_put ? '0 : hit_val;
        n_out_data.evicted     = evict;
        n_out_data.evicted_key = evict ? ev_key : '0;
    end

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // keys held are unique, so at most one cell matches
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the lookup key");

    // valid cells form one run starting at cell 0
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("gap in the valid cell run");

    a_last_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(last_vec))
        else $error("more than one least recent cell");

    // an eviction replaces an entry, so the fill stays the same
    a_evict_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && evict) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
        else $error("fill changed across an eviction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_out_valid && (o_out_data.evicted ? !o_out_data.hit : 1'b1)))
        else $error("accepted beat gave no consistent result");

endmodule

// ===== rtl/lkvc_cell.sv =====
// One entry of the recency-ordered cell row: key, value and valid bit.
// Depends on lkvc_pkg. Loads from its more recent neighbor (or the head data) when enabled.
module lkvc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [lkvc_pkg::VAL_W-1:0] i_value,
    input  logic                       i_valid,
    input  logic [lkvc_pkg::KEY_W-1:0] i_lookup_key,
    input  logic                       i_prev_valid,
    input  logic                       i_next_valid,
    output logic [lkvc_pkg::KEY_W-1:0] o_key,
    output logic [lkvc_pkg::VAL_W-1:0] o_value,
    output logic                       o_valid,
    output lkvc_pkg::t_cell_status     o_status
);

    logic                       r_valid;
    logic [lkvc_pkg::KEY_W-1:0] r_key;
    logic [lkvc_pkg::VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    always_comb begin
        o_status.match      = r_valid && (r_key == i_lookup_key);
        o_status.last_valid = r_valid && !i_next_valid;
        o_status.first_free = !r_valid && i_prev_valid;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== tb/sv/tb_lru_key_value_cache.sv =====
// Self-checking testbench for lru_key_value_cache: directed table, then randomized get/put traffic.
// Depends on lkvc_pkg and the RTL of the cache; results are checked against a recency-rank model.
module tb_lru_key_value_cache;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int CACHE_DEPTH     = lkvc_pkg::DEPTH_DEF;
    localparam int KEY_POOL_SIZE   = 24;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int PRESSURE_PHASE  = 8;
    localparam int HOLD_CYCLES     = 60;
    localparam int TAIL_CYCLES     = 4;
    localparam int N_DIRECTED      = 24;

    typedef struct packed {
        logic                       is_cfg;
        logic [lkvc_pkg::CFG_W-1:0] cap;
        lkvc_pkg::t_in_item         req;
        logic                       typed;  // want holds the expected beat
        lkvc_pkg::t_out_item        want;
    } t_dir_row;

    localparam lkvc_pkg::t_out_item MISS = '{1'b0, 32'h0000_0000, 1'b0, 16'h0000};
    localparam lkvc_pkg::t_in_item  NOP  = '{lkvc_pkg::CMD_GET, 16'h0000, 32'h0000_0000};

    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0000, 32'h0000_0000}, 1'b1, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0000, 32'h0000_0000}, 1'b1, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0000}},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0000, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 16'h0000}},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0000, 32'hA5A5_A5A5}, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 16'h0000}},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0000, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'hA5A5_A5A5, 1'b0, 16'h0000}},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h1234, 32'h5A5A_5A5A}, 1'b1, MISS},
        // capacity dropped below the fill: each put miss evicts one
        '{1'b1, 5'd1,  NOP, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0001, 32'h0000_0001}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0002, 32'h0000_0002}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0001, 32'h0000_0000}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0003, 32'h0000_0003}, 1'b0, MISS},
        // zero acts as one
        '{1'b1, 5'd0,  NOP, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0004, 32'h0000_0004}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0004, 32'h0000_0007}, 1'b0, MISS},
        // above depth clamps to depth
        '{1'b1, 5'd31, NOP, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0005, 32'h0000_0005}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0003, 32'h0000_0000}, 1'b0, MISS},
        '{1'b1, 5'd2,  NOP, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0006, 32'h0000_0006}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_PUT, 16'h0007, 32'h0000_0007}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0005, 32'h0000_0000}, 1'b0, MISS},
        '{1'b0, 5'd0,  '{lkvc_pkg::CMD_GET, 16'h0007, 32'h0000_0000}, 1'b0, MISS}
    };

    localparam logic [lkvc_pkg::CFG_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd9, 5'd2, 5'd17, 5'd16, 5'd5, 5'd3, 5'd12
    };

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [lkvc_pkg::CFG_W-1:0] i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    lkvc_pkg::t_in_item         i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    lkvc_pkg::t_out_item        o_out_data;

    // shadow copy of the cache, recency rank 0 = most recent
    logic                       shadow_valid [CACHE_DEPTH] = '{default: 1'b0};
    logic [lkvc_pkg::KEY_W-1:0] shadow_key   [CACHE_DEPTH] = '{default: '0};
    logic [lkvc_pkg::VAL_W-1:0] shadow_value [CACHE_DEPTH] = '{default: '0};
    int                         shadow_age   [CACHE_DEPTH] = '{default: 0};
    int                         shadow_count = 0;
    logic [lkvc_pkg::CFG_W-1:0] shadow_cap   = lkvc_pkg::CAP_RESET;

    lkvc_pkg::t_out_item pending_replies [$];
    int                  fault_count      = 0;
    int                  send_idle_pct    = 0;
    int                  recv_idle_pct    = 0;
    logic                backpressure_req = 1'b0;

    lru_key_value_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic lkvc_pkg::t_out_item lru_access(input lkvc_pkg::t_in_item req);
        lkvc_pkg::t_out_item res;
        int                  found;
        int                  victim;
        int                  slot;
        int                  cap_eff;
        int                  old_age;
        res    = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == req.lookup_key) found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (req.cmd == lkvc_pkg::CMD_GET) res.read_value = shadow_value[found];
            else shadow_value[found] = req.write_value;
            old_age = shadow_age[found];
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (shadow_valid[i] && shadow_age[i] < old_age) shadow_age[i]++;
            end
            shadow_age[found] = 0;
        end else if (req.cmd == lkvc_pkg::CMD_PUT) begin
            cap_eff = int'(shadow_cap);
            if (cap_eff == 0) cap_eff = 1;
            if (cap_eff > CACHE_DEPTH) cap_eff = CACHE_DEPTH;
            if (shadow_count >= cap_eff) begin
                for (int i = 0; i < CACHE_DEPTH; i++) begin
                    if (shadow_valid[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                        victim = i;
                end
                if (victim >= 0) begin
                    res.evicted     = 1'b1;
                    res.evicted_key = shadow_key[victim];
                    shadow_valid[victim] = 1'b0;
                    if (shadow_count > 0) shadow_count--;
                    slot = victim;
                end
            end
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (slot < 0 && !shadow_valid[i]) slot = i;
            end
            if (slot >= 0) begin
                for (int i = 0; i < CACHE_DEPTH; i++) begin
                    if (shadow_valid[i]) shadow_age[i]++;
                end
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = req.lookup_key;
                shadow_value[slot] = req.write_value;
                shadow_age[slot]   = 0;
                shadow_count++;
            end
        end
        return res;
    endfunction

    // holds the beat until accepted, then logs what the cache should answer
    task automatic offer_request(input lkvc_pkg::t_in_item req, input logic typed,
                                 input lkvc_pkg::t_out_item want);
        lkvc_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = lru_access(req);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] cap);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_cap = cap;
    endtask

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fault_count++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (backpressure_req) begin
                backpressure_req <= 1'b0;
                i_out_ready      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    lkvc_pkg::t_out_item expected_beat;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("result beat with no request pending: %p", o_out_data);
                fault_count++;
            end else begin
                expected_beat = pending_replies.pop_front();
                check_field("hit", 32'(expected_beat.hit), 32'(o_out_data.hit));
                check_field("read_value", expected_beat.read_value, o_out_data.read_value);
                check_field("evicted", 32'(expected_beat.evicted), 32'(o_out_data.evicted));
                check_field("evicted_key", 32'(expected_beat.evicted_key),
                            32'(o_out_data.evicted_key));
            end
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [lkvc_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
        lkvc_pkg::t_in_item         req;
        int                         sel;

        for (int k = 0; k < KEY_POOL_SIZE; k++) begin
            key_pool[k] = lkvc_pkg::KEY_W'($urandom_range(0, 65535));
        end
        send_idle_pct = 33;
        recv_idle_pct = 87;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED_ROWS[r].is_cfg) write_capacity(DIRECTED_ROWS[r].cap);
            else offer_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed,
                               DIRECTED_ROWS[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 33;
                recv_idle_pct = 87;
            end else if (ph < 8) begin
                send_idle_pct = 87;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(PHASE_CAPS[ph]);
            if (ph == PRESSURE_PHASE) backpressure_req <= 1'b1;
            repeat (ITEMS_PER_PHASE) begin
                // mostly keys from a small pool so hits and evictions are frequent
                req.cmd = $urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET;
                sel = $urandom_range(0, 99);
                if (sel < 80) req.lookup_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                else if (sel < 90) req.lookup_key = lkvc_pkg::KEY_W'($urandom_range(0, 65535));
                else req.lookup_key = (sel < 95) ? '0 : '1;
                sel = $urandom_range(0, 99);
                if (sel < 5) req.write_value = '0;
                else if (sel < 10) req.write_value = '1;
                else req.write_value = $urandom;
                offer_request(req, 1'b0, MISS);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache.sv
tb/sv/tb_lru_key_value_cache.sv
